@@ rtl/core/durs_pkg.sv @@
// Shared types and constants for the dual ultrasonic ranging sequencer.
`timescale 1ns / 1ps

package durs_pkg;

    typedef enum logic [2:0] {
        PH_LTRIG_LOW  = 3'd0,
        PH_LTRIG_HIGH = 3'd1,
        PH_LWAIT      = 3'd2,
        PH_LGAP       = 3'd3,
        PH_RTRIG_LOW  = 3'd4,
        PH_RTRIG_HIGH = 3'd5,
        PH_RWAIT      = 3'd6,
        PH_RGAP       = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        REG_ECHO_TIMEOUT = 2'd0,
        REG_GAP          = 2'd1,
        REG_TRIG_HIGH    = 2'd2,
        REG_SCALE        = 2'd3
    } reg_idx_t;

    localparam int          SCALE_FRAC       = 14;
    localparam int          RANGE_W          = 15;
    localparam int          RANGE_MAX        = 16383;
    localparam logic [16:0] TRIG_LOW_TICKS   = 17'd2;

    localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd28000;
    localparam logic [15:0] GAP_RST          = 16'd30000;
    localparam logic [7:0]  TRIG_HIGH_RST    = 8'd10;
    localparam logic [13:0] SCALE_RST        = 14'd2785;

endpackage

@@ rtl/core/dual_ultrasonic_ranging_sequencer.sv @@
// Dual ultrasonic ranging sequencer: trigger sequencing, echo timing and range scaling.
`timescale 1ns / 1ps

// One input transaction is one microsecond tick of the two echo levels and produces exactly
// one output transaction with both trigger levels, the latest left and right ranges in mm
// (-1 when no echo) and flags marking the tick on which a range was rewritten. The block
// takes one tick per clock cycle and registers each result; while a result waits the input
// stalls, and a new tick enters in the same cycle that the waiting result is taken. The
// sensors fire alternately: trigger low for 2 ticks, high for trigger_high_ticks, wait up
// to echo_timeout_ticks for a complete echo pulse, then stay quiet for gap_ticks. Range is
// (width * scale_q14) >> 14, capped at 16383.
// Write the registers only while no transaction is in flight.
module dual_ultrasonic_ranging_sequencer #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] left_echo, [1] right_echo, [7:2] zero
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] left_trigger, [1] right_trigger, [16:2] left_range_mm, [31:17] right_range_mm,
    // [32] left_updated, [33] right_updated, [39:34] zero
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import durs_pkg::*;

    localparam int PROD_W = COUNT_BITS + SCALE_FRAC;
    localparam int MM_W   = (COUNT_BITS > RANGE_W) ? COUNT_BITS : RANGE_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic                  prev;
        logic [COUNT_BITS-1:0] high;
        logic [COUNT_BITS-1:0] width;
        logic                  ready;
    } echo_t;

    function automatic echo_t echo_step(echo_t s, logic level);
        echo_t r;
        r = s;
        if (level && !s.prev) begin
            r.high = COUNT_BITS'(1);
        end else if (level && s.prev) begin
            if (s.high != COUNT_MAX) begin
                r.high = s.high + COUNT_BITS'(1);
            end
        end else if (!level && s.prev) begin
            r.width = s.high;
            r.ready = 1'b1;
        end
        r.prev = level;
        return r;
    endfunction

    logic [15:0] echo_timeout_reg;
    logic [15:0] gap_reg;
    logic [7:0]  trig_high_reg;
    logic [13:0] scale_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    echo_t       l_echo_reg, l_echo_next, r_echo_reg, r_echo_next;
    echo_t       l_echo_e, r_echo_e;
    logic signed [RANGE_W-1:0] l_range_reg, l_range_next, r_range_reg, r_range_next;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic                  s_fire;
    logic                  cfg_wr;
    reg_idx_t              reg_idx;
    logic [16:0]           timer_inc;
    logic                  timeout_hit;
    logic [COUNT_BITS-1:0] wait_width;
    logic [PROD_W-1:0]     product;
    logic [MM_W-1:0]       mm_ext;
    logic [RANGE_W-1:0]    range_val;
    logic                  l_trig, r_trig, l_upd, r_upd;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx)
            REG_ECHO_TIMEOUT: prdata = {16'd0, echo_timeout_reg};
            REG_GAP:          prdata = {16'd0, gap_reg};
            REG_TRIG_HIGH:    prdata = {24'd0, trig_high_reg};
            REG_SCALE:        prdata = {18'd0, scale_reg};
        endcase
    end

    assign l_echo_e    = echo_step(l_echo_reg, s_tdata[0]);
    assign r_echo_e    = echo_step(r_echo_reg, s_tdata[1]);
    assign timer_inc   = {1'b0, timer_reg} + 17'd1;
    assign timeout_hit = timer_inc >= {1'b0, echo_timeout_reg};
    assign wait_width  = (phase_reg == PH_RWAIT) ? r_echo_e.width : l_echo_e.width;
    assign product     = PROD_W'(wait_width) * PROD_W'(scale_reg);
    assign mm_ext      = MM_W'(product[PROD_W-1:SCALE_FRAC]);
    assign range_val   = (mm_ext > MM_W'(RANGE_MAX)) ? RANGE_W'(RANGE_MAX)
                                                     : mm_ext[RANGE_W-1:0];

    always_comb begin
        phase_next   = phase_reg;
        timer_next   = timer_inc[15:0];
        l_echo_next  = l_echo_e;
        r_echo_next  = r_echo_e;
        l_range_next = l_range_reg;
        r_range_next = r_range_reg;
        unique case (phase_reg)
            PH_LTRIG_LOW: begin
                l_echo_next.ready = 1'b0;
                if (timer_inc >= TRIG_LOW_TICKS) begin
                    phase_next = PH_LTRIG_HIGH;
                    timer_next = '0;
                end
            end
            PH_LTRIG_HIGH: begin
                if (timer_inc >= {9'd0, trig_high_reg}) begin
                    phase_next = PH_LWAIT;
                    timer_next = '0;
                end
            end
            PH_LWAIT: begin
                if (l_echo_e.ready) begin
                    l_range_next      = range_val;
                    l_echo_next.ready = 1'b0;
                    phase_next        = PH_LGAP;
                    timer_next        = '0;
                end else if (timeout_hit) begin
                    l_range_next = '1;
                    phase_next   = PH_LGAP;
                    timer_next   = '0;
                end
            end
            PH_LGAP: begin
                if (timer_inc >= {1'b0, gap_reg}) begin
                    phase_next = PH_RTRIG_LOW;
                    timer_next = '0;
                end
            end
            PH_RTRIG_LOW: begin
                r_echo_next.ready = 1'b0;
                if (timer_inc >= TRIG_LOW_TICKS) begin
                    phase_next = PH_RTRIG_HIGH;
                    timer_next = '0;
                end
            end
            PH_RTRIG_HIGH: begin
                if (timer_inc >= {9'd0, trig_high_reg}) begin
                    phase_next = PH_RWAIT;
                    timer_next = '0;
                end
            end
            PH_RWAIT: begin
                if (r_echo_e.ready) begin
                    r_range_next      = range_val;
                    r_echo_next.ready = 1'b0;
                    phase_next        = PH_RGAP;
                    timer_next        = '0;
                end else if (timeout_hit) begin
                    r_range_next = '1;
                    phase_next   = PH_RGAP;
                    timer_next   = '0;
                end
            end
            PH_RGAP: begin
                if (timer_inc >= {1'b0, gap_reg}) begin
                    phase_next = PH_LTRIG_LOW;
                    timer_next = '0;
                end
            end
        endcase
    end

    always_comb begin
        l_trig = (phase_reg == PH_LTRIG_HIGH);
        r_trig = (phase_reg == PH_RTRIG_HIGH);
        l_upd  = (phase_reg == PH_LWAIT) && (l_echo_e.ready || timeout_hit);
        r_upd  = (phase_reg == PH_RWAIT) && (r_echo_e.ready || timeout_hit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_timeout_reg <= ECHO_TIMEOUT_RST;
            gap_reg          <= GAP_RST;
            trig_high_reg    <= TRIG_HIGH_RST;
            scale_reg        <= SCALE_RST;
            phase_reg        <= PH_LTRIG_LOW;
            timer_reg        <= '0;
            l_echo_reg       <= '0;
            r_echo_reg       <= '0;
            l_range_reg      <= '1;
            r_range_reg      <= '1;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_idx)
                    REG_ECHO_TIMEOUT: echo_timeout_reg <= pwdata[15:0];
                    REG_GAP:          gap_reg          <= pwdata[15:0];
                    REG_TRIG_HIGH:    trig_high_reg    <= pwdata[7:0];
                    REG_SCALE:        scale_reg        <= pwdata[13:0];
                endcase
            end
            if (s_fire) begin
                phase_reg   <= phase_next;
                timer_reg   <= timer_next;
                l_echo_reg  <= l_echo_next;
                r_echo_reg  <= r_echo_next;
                l_range_reg <= l_range_next;
                r_range_reg <= r_range_next;
            end
            if (s_tready) begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= {6'd0, r_upd, l_upd, r_range_next, l_range_next, r_trig, l_trig};
        end
    end

    a_one_trigger: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("both triggers high in one transaction");

    a_one_update: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
        else $error("both ranges rewritten in one transaction");

    a_left_to_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && l_upd) |=> (phase_reg == PH_LGAP) && (timer_reg == '0))
        else $error("left measurement did not enter gap");

    a_right_to_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && r_upd) |=> (phase_reg == PH_RGAP) && (timer_reg == '0))
        else $error("right measurement did not enter gap");

    a_trig_low_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LTRIG_LOW || phase_reg == PH_RTRIG_LOW) |-> (timer_reg < 16'd2))
        else $error("trigger low phase overran");

endmodule
